/* rtl/ocp_pkg.sv */
// Shared types and constants for the outline-to-cubic path unit.
// Holds the request and result item structs, command and kind codes and the
// divide-by-three constants. No dependencies.
package ocp_pkg;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] ctl1_x;
        logic signed [31:0] ctl1_y;
        logic signed [31:0] ctl2_x;
        logic signed [31:0] ctl2_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
    } t_req;

    typedef struct packed {
        logic [2:0]         elem_kind;
        logic signed [39:0] out_x1;
        logic signed [39:0] out_y1;
        logic signed [39:0] out_x2;
        logic signed [39:0] out_y2;
        logic signed [39:0] out_x3;
        logic signed [39:0] out_y3;
    } t_res;

    // Stage load enables for the divide-by-three unit.
    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } t_div_ctl;

    localparam logic [2:0] REQ_MOVE  = 3'd0;
    localparam logic [2:0] REQ_LINE  = 3'd1;
    localparam logic [2:0] REQ_QUAD  = 3'd2;
    localparam logic [2:0] REQ_CUBIC = 3'd3;
    localparam logic [2:0] REQ_CLOSE = 3'd4;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_MOVETO  = 3'd1;
    localparam logic [2:0] KIND_LINETO  = 3'd2;
    localparam logic [2:0] KIND_CURVETO = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [2:0] CFG_M_XX    = 3'd0;
    localparam logic [2:0] CFG_M_XY    = 3'd1;
    localparam logic [2:0] CFG_M_YX    = 3'd2;
    localparam logic [2:0] CFG_M_YY    = 3'd3;
    localparam logic [2:0] CFG_SHIFT_X = 3'd4;
    localparam logic [2:0] CFG_SHIFT_Y = 3'd5;

    // ceil(2^41 / 3): floor(u / 3) == (u * DIV3_RECIP) >> 41 for u < 2^41.
    localparam logic [39:0] DIV3_RECIP = 40'd733007751851;
    // 3 * 2^38, added to make a 40-bit signed value non-negative.
    localparam logic [40:0] DIV3_BIAS  = 41'd824633720832;
    // 2^38, the quotient of the bias.
    localparam logic [41:0] DIV3_QOFS  = 42'd274877906944;

    localparam logic signed [49:0] MAX40 = 50'sd549755813887;
    localparam logic signed [49:0] MIN40 = -50'sd549755813888;

    function automatic logic signed [39:0] sat40(input logic signed [49:0] v);
        logic signed [49:0] c;
        if (v > MAX40) begin
            c = MAX40;
        end else if (v < MIN40) begin
            c = MIN40;
        end else begin
            c = v;
        end
        return c[39:0];
    endfunction

endpackage

/* rtl/ocp_div3.sv */
// Two-stage floor division of a 40-bit signed value by three.
// Returns the quotient and the remainder (0 to 2). Depends on ocp_pkg.
module ocp_div3 import ocp_pkg::*; (
    input  logic               i_clk,
    input  t_div_ctl           i_ctl,
    input  logic signed [39:0] i_x,
    output logic signed [39:0] o_q,
    output logic [1:0]         o_r
);

    logic [40:0] u;
    logic [40:0] r_pp_ll;
    logic [40:0] r_pp_lh;
    logic [39:0] r_pp_hl;
    logic [39:0] r_pp_hh;
    logic [1:0]  r_u_lo;
    logic [81:0] sum;
    logic [40:0] qu;
    logic [41:0] q_full;
    logic [1:0]  r_mod;
    logic signed [39:0] r_q;
    logic [1:0]  r_r;

    // The bias is a multiple of three, so it moves the quotient by a constant.
    assign u = {i_x[39], i_x} + DIV3_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_a) begin
            r_pp_ll <= {20'b0, u[20:0]} * {21'b0, DIV3_RECIP[19:0]};
            r_pp_lh <= {20'b0, u[20:0]} * {21'b0, DIV3_RECIP[39:20]};
            r_pp_hl <= {20'b0, u[40:21]} * {20'b0, DIV3_RECIP[19:0]};
            r_pp_hh <= {20'b0, u[40:21]} * {20'b0, DIV3_RECIP[39:20]};
            r_u_lo  <= u[1:0];
        end
    end

    always_comb begin
        sum    = {1'b0, r_pp_hh, 41'b0} + {21'b0, r_pp_hl, 21'b0}
               + {21'b0, r_pp_lh, 20'b0} + {41'b0, r_pp_ll};
        qu     = sum[81:41];
        q_full = {1'b0, qu} - DIV3_QOFS;
        // The remainder is below four, so two bits of u - 3*qu give it exactly.
        r_mod  = r_u_lo - (qu[1:0] + {qu[0], 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_b) begin
            r_q <= $signed(q_full[39:0]);
            r_r <= r_mod;
        end
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

/* rtl/outline_to_cubic_path_unit.sv */
// Top level of the outline-to-cubic path unit: affine mapping, quadratic
// raising and path state. Depends on ocp_pkg and ocp_div3.
//
// Usage: outline commands enter on the request channel (i_in_valid,
// o_in_ready, i_in_req) and each produces exactly one path element on the
// result channel (o_out_valid, i_out_ready, o_out_res), in order.
// From acceptance to o_out_valid an item passes the input register, multiplier
// register, mapped point, two divide-by-three stages, the quadratic pre-sum and
// the result register. Throughput is one item per cycle while the receiver
// takes results; the 32x32 multiplier stage and the constant divide are
// pipelined, and the path state is read and updated in the final stage only.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at
// once. The user must make them while the block is idle; the block does not check.
// Reset loads the identity matrix with zero translation, empties the pipe
// and forgets the last point. When the receiver stalls, each stage still
// fills its bubbles; o_in_ready falls only once all seven stages hold items.
module outline_to_cubic_path_unit import ocp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_res        o_out_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data
);

    // Mapped points: index 0 first control, 1 second control, 2 end point.
    typedef struct packed {
        logic [2:0]              req_type;
        logic [2:0][39:0]        px;
        logic [2:0][39:0]        py;
    } t_pts;

    function automatic logic signed [39:0] map_axis(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input logic signed [39:0] t);
        logic [64:0] s;
        logic [48:0] h;
        logic [49:0] v;
        s = {a[63], a} + {b[63], b};
        h = s[64:16];
        v = {h[48], h} + {{10{t[39]}}, t};
        return sat40($signed(v));
    endfunction

    // p + q + up - dn, saturated.
    function automatic logic signed [39:0] adj_sum(input logic signed [41:0] p,
                                                   input logic signed [39:0] q,
                                                   input logic up,
                                                   input logic dn);
        logic [49:0] v;
        v = {{8{p[41]}}, p} + {{10{q[39]}}, q} + {49'b0, up} - {49'b0, dn};
        return sat40($signed(v));
    endfunction

    logic signed [31:0] r_m_xx, r_m_xy, r_m_yx, r_m_yy;
    logic signed [39:0] r_shift_x, r_shift_y;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_out_valid;
    logic ld1, ld2, ld3, ld4, ld5, ld6, ld_out;

    t_req               r_req;
    logic signed [31:0] s1_px [3];
    logic signed [31:0] s1_py [3];
    logic [2:0]         r_type2;
    logic signed [63:0] r_pxa [3];
    logic signed [63:0] r_pxb [3];
    logic signed [63:0] r_pya [3];
    logic signed [63:0] r_pyb [3];
    t_pts               r_pts3, r_pts4, r_pts5, r_pts6;
    t_pts               n_pts3;

    t_div_ctl           div_ctl;
    logic signed [39:0] q_cx, q_cy, q_ex, q_ey;
    logic [1:0]         m_cx, m_cy, m_ex, m_ey;

    logic signed [41:0] r_pcx, r_pcy;
    logic signed [39:0] r_qex, r_qey;
    logic [1:0]         r_rcx, r_rcy, r_rex, r_rey;

    logic               r_have;
    logic signed [39:0] r_last_x, r_last_y, r_last_qx, r_last_qy;
    logic [1:0]         r_last_rx, r_last_ry;

    logic signed [39:0] cx, cy, dx, dy, ex, ey;
    logic               dup, emit, n_have;
    t_res               n_res;
    t_res               r_res;

    // Each stage loads when it is empty or its content moves on.
    assign ld_out     = !r_out_valid || i_out_ready;
    assign ld6        = !r_v6 || ld_out;
    assign ld5        = !r_v5 || ld6;
    assign ld4        = !r_v4 || ld5;
    assign ld3        = !r_v3 || ld4;
    assign ld2        = !r_v2 || ld3;
    assign ld1        = !r_v1 || ld2;
    assign o_in_ready = ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_xx      <= 32'sd65536;
            r_m_xy      <= '0;
            r_m_yx      <= '0;
            r_m_yy      <= 32'sd65536;
            r_shift_x   <= '0;
            r_shift_y   <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_M_XX:    r_m_xx    <= $signed(i_cfg_data[31:0]);
                    CFG_M_XY:    r_m_xy    <= $signed(i_cfg_data[31:0]);
                    CFG_M_YX:    r_m_yx    <= $signed(i_cfg_data[31:0]);
                    CFG_M_YY:    r_m_yy    <= $signed(i_cfg_data[31:0]);
                    CFG_SHIFT_X: r_shift_x <= $signed(i_cfg_data);
                    CFG_SHIFT_Y: r_shift_y <= $signed(i_cfg_data);
                    default: begin
                    end
                endcase
            end
            if (ld1) r_v1 <= i_in_valid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
            if (ld5) r_v5 <= r_v4;
            if (ld6) r_v6 <= r_v5;
            if (ld_out) begin
                r_out_valid <= r_v6;
                if (r_v6) begin
                    r_have <= n_have;
                end
            end
        end
    end

    assign s1_px[0] = r_req.ctl1_x;
    assign s1_py[0] = r_req.ctl1_y;
    assign s1_px[1] = r_req.ctl2_x;
    assign s1_py[1] = r_req.ctl2_y;
    assign s1_px[2] = r_req.end_x;
    assign s1_py[2] = r_req.end_y;

    always_comb begin
        n_pts3.req_type = r_type2;
        for (int k = 0; k < 3; k++) begin
            n_pts3.px[k] = map_axis(r_pxa[k], r_pxb[k], r_shift_x);
            n_pts3.py[k] = map_axis(r_pya[k], r_pyb[k], r_shift_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_req <= i_in_req;
        end
        if (ld2) begin
            r_type2 <= r_req.req_type;
            for (int k = 0; k < 3; k++) begin
                r_pxa[k] <= r_m_xx * s1_px[k];
                r_pxb[k] <= r_m_xy * s1_py[k];
                r_pya[k] <= r_m_yx * s1_px[k];
                r_pyb[k] <= r_m_yy * s1_py[k];
            end
        end
        if (ld3) r_pts3 <= n_pts3;
        if (ld4) r_pts4 <= r_pts3;
        if (ld5) r_pts5 <= r_pts4;
        if (ld6) begin
            r_pts6 <= r_pts5;
            r_pcx  <= {{2{r_pts5.px[0][39]}}, r_pts5.px[0]} - {{2{q_cx[39]}}, q_cx};
            r_pcy  <= {{2{r_pts5.py[0][39]}}, r_pts5.py[0]} - {{2{q_cy[39]}}, q_cy};
            r_qex  <= q_ex;
            r_qey  <= q_ey;
            r_rcx  <= m_cx;
            r_rcy  <= m_cy;
            r_rex  <= m_ex;
            r_rey  <= m_ey;
        end
    end

    assign div_ctl.ld_a = ld4;
    assign div_ctl.ld_b = ld5;

    ocp_div3 u_div_cx (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_x   ($signed(r_pts3.px[0])),
        .o_q   (q_cx),
        .o_r   (m_cx)
    );

    ocp_div3 u_div_cy (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_x   ($signed(r_pts3.py[0])),
        .o_q   (q_cy),
        .o_r   (m_cy)
    );

    ocp_div3 u_div_ex (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_x   ($signed(r_pts3.px[2])),
        .o_q   (q_ex),
        .o_r   (m_ex)
    );

    ocp_div3 u_div_ey (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_x   ($signed(r_pts3.py[2])),
        .o_q   (q_ey),
        .o_r   (m_ey)
    );

    assign cx = $signed(r_pts6.px[0]);
    assign cy = $signed(r_pts6.py[0]);
    assign dx = $signed(r_pts6.px[1]);
    assign dy = $signed(r_pts6.py[1]);
    assign ex = $signed(r_pts6.px[2]);
    assign ey = $signed(r_pts6.py[2]);

    // With a = 3qa + ra and b = 3qb + rb, trunc((a - b) / 3) is
    // qa - qb - (ra < rb), plus one when a < b and ra != rb.
    always_comb begin
        n_res  = '0;
        dup    = r_have && (ex == r_last_x) && (ey == r_last_y);
        n_have = r_have;
        unique case (r_pts6.req_type)
            REQ_MOVE, REQ_LINE: begin
                if (!dup) begin
                    n_res.elem_kind = (r_pts6.req_type == REQ_MOVE) ? KIND_MOVETO
                                                                    : KIND_LINETO;
                    n_res.out_x3    = ex;
                    n_res.out_y3    = ey;
                end
            end
            REQ_QUAD: begin
                if (!r_have) begin
                    n_res.elem_kind = KIND_ERROR;
                end else begin
                    n_res.elem_kind = KIND_CURVETO;
                    n_res.out_x1 = adj_sum(r_pcx, r_last_qx, r_rcx < r_last_rx,
                                           (cx < r_last_x) && (r_rcx != r_last_rx));
                    n_res.out_y1 = adj_sum(r_pcy, r_last_qy, r_rcy < r_last_ry,
                                           (cy < r_last_y) && (r_rcy != r_last_ry));
                    n_res.out_x2 = adj_sum(r_pcx, r_qex,
                                           (ex < cx) && (r_rex != r_rcx), r_rex < r_rcx);
                    n_res.out_y2 = adj_sum(r_pcy, r_qey,
                                           (ey < cy) && (r_rey != r_rcy), r_rey < r_rcy);
                    n_res.out_x3 = ex;
                    n_res.out_y3 = ey;
                end
            end
            REQ_CUBIC: begin
                n_res.elem_kind = KIND_CURVETO;
                n_res.out_x1    = cx;
                n_res.out_y1    = cy;
                n_res.out_x2    = dx;
                n_res.out_y2    = dy;
                n_res.out_x3    = ex;
                n_res.out_y3    = ey;
            end
            REQ_CLOSE: begin
                n_res.elem_kind = KIND_END;
                n_have          = 1'b0;
            end
            default: begin
                n_res.elem_kind = KIND_NONE;
            end
        endcase
        emit = (n_res.elem_kind == KIND_MOVETO) || (n_res.elem_kind == KIND_LINETO)
            || (n_res.elem_kind == KIND_CURVETO);
        if (emit) begin
            n_have = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_res <= n_res;
            if (r_v6 && emit) begin
                r_last_x  <= ex;
                r_last_y  <= ey;
                r_last_qx <= r_qex;
                r_last_qy <= r_qey;
                r_last_rx <= r_rex;
                r_last_ry <= r_rey;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_res;

endmodule

/* sim/tb.sv */
// Self-checking testbench for outline_to_cubic_path_unit: outline commands go in,
// and each cubic-path element that comes out is checked against a predictor of
// the block's own. Depends on rtl/ocp_pkg.sv and rtl/outline_to_cubic_path_unit.sv.
module tb import ocp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;

    localparam logic signed [65:0] SAT_HI     = 66'sd549755813887;
    localparam logic signed [65:0] SAT_LO     = -66'sd549755813888;
    localparam logic signed [65:0] CTL_DIVSOR = 66'sd3;

    localparam logic signed [31:0] C32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] C32_MIN = 32'sh80000000;
    localparam logic signed [39:0] C40_MAX = 40'sh7fffffffff;
    localparam logic signed [39:0] C40_MIN = 40'sh8000000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_req        i_in_req;
    logic        o_out_valid;
    logic        i_out_ready;
    t_res        o_out_res;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [39:0] i_cfg_data;

    outline_to_cubic_path_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor copy of the matrix and of the pen position.
    logic signed [31:0] mat_xx = 32'sd65536;
    logic signed [31:0] mat_xy = 32'sd0;
    logic signed [31:0] mat_yx = 32'sd0;
    logic signed [31:0] mat_yy = 32'sd65536;
    logic signed [39:0] ofs_x  = 40'sd0;
    logic signed [39:0] ofs_y  = 40'sd0;
    logic signed [39:0] pen_x  = 40'sd0;
    logic signed [39:0] pen_y  = 40'sd0;
    logic               pen_valid = 1'b0;

    t_res exp_elems[$];
    int   n_errors = 0;
    int   n_sent = 0;
    int   n_elems = 0;
    int   n_settings = 1;
    int   kind_seen[8];
    int   burst_left = 0;
    int   cycle_cnt = 0;
    logic hold_out = 1'b0;
    logic hold_active = 1'b0;
    logic signed [31:0] prev_end_x = 32'sd0;
    logic signed [31:0] prev_end_y = 32'sd0;

    function automatic logic signed [39:0] clamp40(input logic signed [65:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[39:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[39:0];
        end
        return v[39:0];
    endfunction

    // floor((a*x + b*y) / 2^16) + t, the sum kept wide enough to never wrap.
    function automatic logic signed [39:0] map_coord(input logic signed [31:0] a,
                                                     input logic signed [31:0] b,
                                                     input logic signed [39:0] t,
                                                     input logic signed [31:0] x,
                                                     input logic signed [31:0] y);
        logic signed [65:0] wa, wb, wx, wy, wt, acc;
        wa = a;
        wb = b;
        wx = x;
        wy = y;
        wt = t;
        acc = wa * wx + wb * wy;
        return clamp40((acc >>> 16) + wt);
    endfunction

    function automatic void map_point(input logic signed [31:0] px,
                                      input logic signed [31:0] py,
                                      output logic signed [39:0] ox,
                                      output logic signed [39:0] oy);
        ox = map_coord(mat_xx, mat_xy, ofs_x, px, py);
        oy = map_coord(mat_yx, mat_yy, ofs_y, px, py);
    endfunction

    // One third of the way from c toward p, the division truncating toward zero.
    function automatic logic signed [39:0] raise_ctl(input logic signed [39:0] c,
                                                     input logic signed [39:0] p);
        logic signed [65:0] wc, wp;
        wc = c;
        wp = p;
        return clamp40(wc + (wp - wc) / CTL_DIVSOR);
    endfunction

    function automatic t_res path_element(input t_req cmd);
        t_res r;
        logic signed [39:0] ex, ey, cx, cy, dx, dy;
        r = '0;
        r.elem_kind = KIND_NONE;
        map_point(cmd.end_x, cmd.end_y, ex, ey);
        map_point(cmd.ctl1_x, cmd.ctl1_y, cx, cy);
        map_point(cmd.ctl2_x, cmd.ctl2_y, dx, dy);
        case (cmd.req_type)
            REQ_MOVE, REQ_LINE: begin
                // A move or line onto the current pen position is dropped.
                if (!(pen_valid && ex == pen_x && ey == pen_y)) begin
                    r.elem_kind = (cmd.req_type == REQ_MOVE) ? KIND_MOVETO : KIND_LINETO;
                    r.out_x3 = ex;
                    r.out_y3 = ey;
                end
            end
            REQ_QUAD: begin
                if (!pen_valid) begin
                    r.elem_kind = KIND_ERROR;
                end else begin
                    r.elem_kind = KIND_CURVETO;
                    r.out_x1 = raise_ctl(cx, pen_x);
                    r.out_y1 = raise_ctl(cy, pen_y);
                    r.out_x2 = raise_ctl(cx, ex);
                    r.out_y2 = raise_ctl(cy, ey);
                    r.out_x3 = ex;
                    r.out_y3 = ey;
                end
            end
            REQ_CUBIC: begin
                r.elem_kind = KIND_CURVETO;
                r.out_x1 = cx;
                r.out_y1 = cy;
                r.out_x2 = dx;
                r.out_y2 = dy;
                r.out_x3 = ex;
                r.out_y3 = ey;
            end
            REQ_CLOSE: begin
                r.elem_kind = KIND_END;
                pen_valid = 1'b0;
            end
            default: begin
            end
        endcase
        if (r.elem_kind == KIND_MOVETO || r.elem_kind == KIND_LINETO ||
            r.elem_kind == KIND_CURVETO) begin
            pen_x = ex;
            pen_y = ey;
            pen_valid = 1'b1;
        end
        return r;
    endfunction

    function automatic t_req make_cmd(input logic [2:0] kind,
                                      input logic signed [31:0] c1x,
                                      input logic signed [31:0] c1y,
                                      input logic signed [31:0] c2x,
                                      input logic signed [31:0] c2y,
                                      input logic signed [31:0] ex,
                                      input logic signed [31:0] ey);
        t_req c;
        c.req_type = kind;
        c.ctl1_x = c1x;
        c.ctl1_y = c1y;
        c.ctl2_x = c2x;
        c.ctl2_y = c2y;
        c.end_x = ex;
        c.end_y = ey;
        return c;
    endfunction

    // Small coordinates half the time so that curves stay meaningful, with extremes
    // and full-range values in the rest.
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? C32_MAX : C32_MIN;
            1, 2, 3, 4, 5: return $signed(32'($urandom_range(0, 8191)) - 32'd4096);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic t_req rand_cmd(input logic [2:0] kind);
        t_req c;
        c = make_cmd(kind, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord());
        if ($urandom_range(0, 7) == 0) begin
            c.end_x = prev_end_x;
            c.end_y = prev_end_y;
        end
        return c;
    endfunction

    // Offers one item, with a random gap first whenever a burst has run out.
    task automatic send_cmd(input t_req cmd);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_req <= cmd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        exp_elems.push_back(path_element(cmd));
        prev_end_x = cmd.end_x;
        prev_end_y = cmd.end_y;
        n_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (exp_elems.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [39:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_M_XX: mat_xx = val[31:0];
            CFG_M_XY: mat_xy = val[31:0];
            CFG_M_YX: mat_yx = val[31:0];
            CFG_M_YY: mat_yy = val[31:0];
            CFG_SHIFT_X: ofs_x = val;
            CFG_SHIFT_Y: ofs_y = val;
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_matrix(input logic signed [31:0] xx, input logic signed [31:0] xy,
                              input logic signed [31:0] yx, input logic signed [31:0] yy,
                              input logic signed [39:0] tx, input logic signed [39:0] ty);
        drain();
        cfg_write(CFG_M_XX, 40'(xx));
        cfg_write(CFG_M_XY, 40'(xy));
        cfg_write(CFG_M_YX, 40'(yx));
        cfg_write(CFG_M_YY, 40'(yy));
        cfg_write(CFG_SHIFT_X, tx);
        cfg_write(CFG_SHIFT_Y, ty);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    task automatic test_directed();
        send_cmd(make_cmd(REQ_QUAD, C32_MAX, C32_MAX, 0, 0, C32_MIN, C32_MIN));
        send_cmd(make_cmd(REQ_LINE, 0, 0, 0, 0, 100, 200));
        send_cmd(make_cmd(REQ_MOVE, 0, 0, 0, 0, 100, 200));
        send_cmd(make_cmd(REQ_LINE, -1, -1, -1, -1, 100, 200));
        send_cmd(make_cmd(REQ_MOVE, 0, 0, 0, 0, C32_MAX, C32_MAX));
        send_cmd(make_cmd(REQ_LINE, 0, 0, 0, 0, C32_MIN, C32_MIN));
        send_cmd(make_cmd(REQ_QUAD, C32_MAX, C32_MIN, 0, 0, 0, 0));
        send_cmd(make_cmd(REQ_CUBIC, C32_MIN, C32_MAX, C32_MAX, C32_MIN, -1, -1));
        send_cmd(make_cmd(REQ_QUAD, 7, -5, 0, 0, -13, 11));
        send_cmd(make_cmd(REQ_QUAD, -8, 4, 0, 0, 2, -2));
        send_cmd(make_cmd(REQ_CLOSE, C32_MAX, C32_MIN, C32_MAX, C32_MIN, C32_MAX, C32_MIN));
        // After a close there is no pen position, so the same point is drawn again.
        send_cmd(make_cmd(REQ_LINE, 0, 0, 0, 0, 2, -2));
        send_cmd(make_cmd(REQ_CLOSE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(REQ_QUAD, 5, 5, 0, 0, 9, 9));
        send_cmd(make_cmd(REQ_CUBIC, 1, 2, 3, 4, 5, 5));
        send_cmd(make_cmd(REQ_MOVE, 0, 0, 0, 0, 5, 5));
        send_cmd(make_cmd(3'd5, 1, 1, 1, 1, 1, 1));
        send_cmd(make_cmd(3'd6, C32_MAX, C32_MAX, C32_MAX, C32_MAX, C32_MAX, C32_MAX));
        send_cmd(make_cmd(3'd7, C32_MIN, C32_MIN, C32_MIN, C32_MIN, C32_MIN, C32_MIN));
        send_cmd(make_cmd(REQ_CLOSE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(REQ_CLOSE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(REQ_MOVE, 0, 0, 0, 0, 0, 0));
    endtask

    // The receiver stops for a long stretch while items keep coming back to back.
    task automatic test_backpressure();
        drain();
        hold_out = 1'b1;
        wait (hold_active);
        burst_left = 1000;
        repeat (40) send_cmd(rand_cmd(REQ_LINE));
        drain();
    endtask

    task automatic rand_path();
        int nseg;
        t_req c;
        send_cmd(rand_cmd(REQ_MOVE));
        nseg = $urandom_range(1, 10);
        repeat (nseg) begin
            case ($urandom_range(0, 9))
                0: c = rand_cmd(REQ_MOVE);
                1, 2, 3: c = rand_cmd(REQ_LINE);
                4, 5, 6: c = rand_cmd(REQ_QUAD);
                default: c = rand_cmd(REQ_CUBIC);
            endcase
            send_cmd(c);
        end
        if ($urandom_range(0, 3) != 0) begin
            send_cmd(rand_cmd(REQ_CLOSE));
        end
    endtask

    task automatic test_random_paths(input int n_items);
        int start;
        start = n_sent;
        while (n_sent - start < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) send_cmd(rand_cmd(3'($urandom_range(0, 7))));
            end else begin
                rand_path();
            end
        end
    endtask

    task automatic check_field(input string name, input logic [39:0] want,
                               input logic [39:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : elem_check
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_elems++;
            kind_seen[o_out_res.elem_kind]++;
            if (exp_elems.size() == 0) begin
                $display("%0t ns: element with none pending, expected nothing, got %h",
                         $time, o_out_res);
                n_errors++;
            end else begin
                want = exp_elems.pop_front();
                check_field("elem_kind", 40'(want.elem_kind), 40'(o_out_res.elem_kind));
                check_field("out_x1", want.out_x1, o_out_res.out_x1);
                check_field("out_y1", want.out_y1, o_out_res.out_y1);
                check_field("out_x2", want.out_x2, o_out_res.out_x2);
                check_field("out_y2", want.out_y2, o_out_res.out_y2);
                check_field("out_x3", want.out_x3, o_out_res.out_x3);
                check_field("out_y3", want.out_y3, o_out_res.out_y3);
            end
        end
    end

    // Output pacing: stretches of steady, sparse, dense or toggling ready, and a
    // long hold-off when one is requested.
    always begin : out_pacing
        int stretch;
        int mode;
        @(posedge i_clk);
        if (hold_out) begin
            hold_active = 1'b1;
            i_out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active = 1'b0;
            hold_out = 1'b0;
        end else begin
            stretch = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (stretch) begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ~i_out_ready;
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d elements pending",
                     cycle_cnt, exp_elems.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_M_XX;
        i_cfg_data = '0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_paths(260);

        // Extreme factors and offsets drive most results into saturation.
        set_matrix(C32_MAX, C32_MIN, C32_MIN, C32_MAX, C40_MAX, C40_MIN);
        test_random_paths(260);

        // A zero matrix maps every point onto the offset, so most moves and lines drop.
        set_matrix(0, 0, 0, 0, $signed(40'($urandom)), $signed(40'($urandom)));
        test_random_paths(200);

        set_matrix($signed($urandom), $signed($urandom), $signed($urandom),
                   $signed($urandom), {$urandom, 8'($urandom)}, {$urandom, 8'($urandom)});
        test_random_paths(260);

        set_matrix(-32'sd32768, 32'sd196608, 32'sd1, -32'sd65536, -40'sd1000, 40'sd777);
        test_random_paths(200);

        set_matrix(32'sd65536, 0, 0, 32'sd65536, C40_MIN, C40_MAX);
        test_backpressure();
        test_random_paths(100);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run: %0d commands under %0d matrix settings, %0d elements compared",
                 n_sent, n_settings, n_elems);
        $display("Kinds seen: none %0d, move %0d, line %0d, curve %0d, end %0d, error %0d",
                 kind_seen[KIND_NONE], kind_seen[KIND_MOVETO], kind_seen[KIND_LINETO],
                 kind_seen[KIND_CURVETO], kind_seen[KIND_END], kind_seen[KIND_ERROR]);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ocp_pkg.sv
rtl/ocp_div3.sv
rtl/outline_to_cubic_path_unit.sv
sim/tb.sv
